[sv/b58d_pkg.sv]
`timescale 1ns / 1ps

package b58d_pkg;

    // Buffer geometry
    localparam int BUF_BYTES = 32;
    localparam int IDX_W     = $clog2(BUF_BYTES);
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);
    localparam int TOT_W     = CNT_W + 1;

    // Field widths
    localparam int CHAR_W = 8;
    localparam int BYTE_W = 8;
    localparam int DIG_W  = 6;

    // Multiply-accumulate: 58 * byte + carry fits in 14 bits, carry stays below 58
    localparam int RADIX = 58;
    localparam int SUM_W = BYTE_W + DIG_W;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BADCHAR  = 2'd1,
        STS_OVERFLOW = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIN,
        S_ZERO,
        S_BLD,
        S_ONE,
        S_DONE
    } t_state;

    // Alphabet lookup result
    typedef struct packed {
        logic             ok;
        logic [DIG_W-1:0] digit;
    } t_digit;

    // Request bundle from the controller to the byte buffer
    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic             clr;
    } t_ram_req;

    // Map an ASCII character to its digit in the 58-symbol alphabet
    function automatic t_digit digit_of(input logic [CHAR_W-1:0] ch);
        t_digit           res;
        logic [CHAR_W-1:0] diff;
        res  = '0;
        diff = '0;
        case (ch) inside
            [8'h31:8'h39]: begin
                diff = ch - 8'h31;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            [8'h41:8'h48]: begin
                diff = ch - 8'h41 + 8'd9;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            [8'h4A:8'h4E]: begin
                diff = ch - 8'h4A + 8'd17;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            [8'h50:8'h5A]: begin
                diff = ch - 8'h50 + 8'd22;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            [8'h61:8'h6B]: begin
                diff = ch - 8'h61 + 8'd33;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            [8'h6D:8'h7A]: begin
                diff = ch - 8'h6D + 8'd44;
                res  = '{ok: 1'b1, digit: diff[DIG_W-1:0]};
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

[sv/b58d_if.sv]
`timescale 1ns / 1ps

// Input channel: one character per transfer
interface b58d_in_if;
    import b58d_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
    modport source(output valid, output in_char, output in_last, input ready);
    modport sink(input valid, input in_char, input in_last, output ready);
endinterface

// Output channel: one decoded byte or one error result per transfer
interface b58d_out_if;
    import b58d_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_last;
    logic [1:0]        status;
    modport source(output valid, output out_byte, output out_last, output status,
                   input ready);
    modport sink(input valid, input out_byte, input out_last, input status,
                 output ready);
endinterface

[sv/base58_decoder_top.sv]
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Transfer
// i_in      in   in_char[7:0], in_last            valid && ready
// o_out     out  out_byte[7:0], out_last, status   valid && ready
//
// A character other than a leading '1' starts the multiply-by-58 walk, which reads
// and writes one buffer byte per cycle on the RAM.
// A leading '1', an invalid character or any character after an error is
// handled in S_IDLE alone. The last character leads to S_FIN, which sizes the
// result; output bytes follow as the sink takes them, then S_DONE clears the buffer.
// Reset is synchronous; buffer valid bits clear at once, no clearing pass.
// A stalled output holds its register; the next string waits only when a new byte is due.

module base58_decoder_top (
    input logic         i_clk,
    input logic         i_rst_n,
    b58d_in_if.sink     i_in,
    b58d_out_if.source  o_out
);
    import b58d_pkg::*;

    t_ram_req          w_req;
    logic [BYTE_W-1:0] w_rdata;

    // Sequencer and arithmetic
    b58d_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_req   (w_req),
        .i_rdata (w_rdata)
    );

    // Big-endian number buffer
    b58d_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

endmodule

[sv/b58d_ram.sv]
`timescale 1ns / 1ps

module b58d_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  b58d_pkg::t_ram_req          i_req,
    output logic [b58d_pkg::BYTE_W-1:0] o_rdata
);
    import b58d_pkg::*;

    logic [BYTE_W-1:0]    r_mem [BUF_BYTES];
    logic [BUF_BYTES-1:0] r_vld;
    logic [BYTE_W-1:0]    r_rdata;
    logic                 r_rvld;

    // Byte storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    // Per-entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvld <= r_vld[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

[sv/b58d_ctrl.sv]
`timescale 1ns / 1ps

module b58d_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    b58d_in_if.sink                     i_in,
    b58d_out_if.source                  o_out,
    output b58d_pkg::t_ram_req          o_req,
    input  logic [b58d_pkg::BYTE_W-1:0] i_rdata
);
    import b58d_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [DIG_W-1:0]  r_carry, n_carry;
    logic [CNT_W-1:0]  r_first, n_first;
    logic [CNT_W-1:0]  r_lead, n_lead;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_seen, n_seen;
    t_status           r_err, n_err;
    logic              r_lastin, n_lastin;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;
    t_status           r_ostatus, n_ostatus;

    t_digit            w_dig;
    logic [SUM_W-1:0]  w_sum;
    logic [TOT_W-1:0]  w_sig;
    logic [TOT_W-1:0]  w_total;
    logic              w_free;
    t_state            w_after;

    // Datapath: alphabet lookup, byte * 58 + carry, output length
    assign w_dig   = digit_of(i_in.in_char);
    assign w_sum   = SUM_W'(i_rdata) * SUM_W'(RADIX) + SUM_W'(r_carry);
    assign w_sig   = TOT_W'(BUF_BYTES) - TOT_W'(r_first);
    assign w_total = TOT_W'(r_lead) + w_sig;
    assign w_free  = !r_ovalid || o_out.ready;
    assign w_after = i_in.in_last ? S_FIN : S_IDLE;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.out_last = r_olast;
    assign o_out.status   = r_ostatus;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_carry  <= '0;
            r_first  <= CNT_W'(BUF_BYTES);
            r_lead   <= '0;
            r_cnt    <= '0;
            r_seen   <= 1'b0;
            r_err    <= STS_OK;
            r_lastin <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_carry  <= n_carry;
            r_first  <= n_first;
            r_lead   <= n_lead;
            r_cnt    <= n_cnt;
            r_seen   <= n_seen;
            r_err    <= n_err;
            r_lastin <= n_lastin;
            r_ovalid <= n_ovalid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        r_obyte   <= n_obyte;
        r_olast   <= n_olast;
        r_ostatus <= n_ostatus;
    end

    // Next state, buffer requests and output loads
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_first   = r_first;
        n_lead    = r_lead;
        n_cnt     = r_cnt;
        n_seen    = r_seen;
        n_err     = r_err;
        n_lastin  = r_lastin;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_ostatus = r_ostatus;
        o_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_lastin = i_in.in_last;
                    if (r_err != STS_OK) begin
                        n_state = w_after;
                    end else if (!w_dig.ok) begin
                        n_err   = STS_BADCHAR;
                        n_state = w_after;
                    end else if (w_dig.digit == '0 && !r_seen) begin
                        // leading '1': count it, buffer untouched
                        if (r_lead >= CNT_W'(BUF_BYTES)) begin
                            n_err = STS_OVERFLOW;
                        end else begin
                            n_lead = r_lead + 1'b1;
                        end
                        n_state = w_after;
                    end else begin
                        // start the multiply walk at the least significant byte
                        n_seen      = 1'b1;
                        n_carry     = w_dig.digit;
                        n_first     = CNT_W'(BUF_BYTES);
                        n_idx       = IDX_W'(BUF_BYTES - 1);
                        o_req.re    = 1'b1;
                        o_req.raddr = IDX_W'(BUF_BYTES - 1);
                        n_state     = S_MUL;
                    end
                end
            end

            S_MUL: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_idx;
                o_req.wdata = w_sum[BYTE_W-1:0];
                n_carry     = w_sum[SUM_W-1:BYTE_W];
                if (w_sum[BYTE_W-1:0] != '0) begin
                    n_first = CNT_W'(r_idx);
                end
                if (r_idx == '0) begin
                    if (w_sum[SUM_W-1:BYTE_W] != '0) begin
                        n_err = STS_OVERFLOW;
                    end
                    n_state = r_lastin ? S_FIN : S_IDLE;
                end else begin
                    n_idx       = r_idx - 1'b1;
                    o_req.re    = 1'b1;
                    o_req.raddr = r_idx - 1'b1;
                end
            end

            S_FIN: begin
                if (r_err != STS_OK) begin
                    n_state = S_ONE;
                end else if (w_total > TOT_W'(BUF_BYTES)) begin
                    n_err   = STS_OVERFLOW;
                    n_state = S_ONE;
                end else if (w_total == '0) begin
                    n_state = S_ONE;
                end else if (r_lead != '0) begin
                    n_cnt   = r_lead;
                    n_state = S_ZERO;
                end else begin
                    n_idx       = r_first[IDX_W-1:0];
                    o_req.re    = 1'b1;
                    o_req.raddr = r_first[IDX_W-1:0];
                    n_state     = S_BLD;
                end
            end

            // one zero byte per leading '1'
            S_ZERO: begin
                if (w_free) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = '0;
                    n_olast   = (r_cnt == CNT_W'(1)) && (r_first == CNT_W'(BUF_BYTES));
                    n_ostatus = STS_OK;
                    n_cnt     = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_first == CNT_W'(BUF_BYTES)) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx       = r_first[IDX_W-1:0];
                            o_req.re    = 1'b1;
                            o_req.raddr = r_first[IDX_W-1:0];
                            n_state     = S_BLD;
                        end
                    end
                end
            end

            // significant bytes, read data held until the output slot frees
            S_BLD: begin
                if (w_free) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = i_rdata;
                    n_olast   = (r_idx == IDX_W'(BUF_BYTES - 1));
                    n_ostatus = STS_OK;
                    if (r_idx == IDX_W'(BUF_BYTES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx       = r_idx + 1'b1;
                        o_req.re    = 1'b1;
                        o_req.raddr = r_idx + 1'b1;
                    end
                end
            end

            // single result: error code, or the empty value
            S_ONE: begin
                if (w_free) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = '0;
                    n_olast   = 1'b1;
                    n_ostatus = r_err;
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                o_req.clr = 1'b1;
                n_lead    = '0;
                n_seen    = 1'b0;
                n_err     = STS_OK;
                n_first   = CNT_W'(BUF_BYTES);
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE && r_err == STS_OK && r_lead == '0))
        else $error("string state not cleared after done");

    a_carry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_carry < DIG_W'(RADIX)))
        else $error("carry out of range during walk");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != STS_OK) |-> r_olast)
        else $error("error result without last marker");

    a_lead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead <= CNT_W'(BUF_BYTES))
        else $error("leading count above buffer size");

endmodule

[test/base58_decoder_top_tb.sv]
`timescale 1ns / 1ps

module base58_decoder_top_tb;
    import b58d_pkg::*;

    localparam string B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam int RANDOM_CHARS = 90;
    localparam int SETTLE_CYCLES = 60;

    // One decoded byte or one error result
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        t_status           st;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    b58d_in_if  in_if ();
    b58d_out_if out_if ();

    base58_decoder_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the decoder state for the current string
    logic [BYTE_W-1:0] num_bytes [BUF_BYTES];
    int                ones_cnt;
    bit                past_ones;
    t_status           str_status;

    t_decoded          decoded_q [$];
    logic [CHAR_W-1:0] chars_q [$];

    bit quiet_link    = 1'b0;  // no gaps on either side while set
    int fail_cnt      = 0;
    int strings_cnt   = 0;
    int taken_cnt     = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int error_strings = 0;

    function automatic int alpha_index(input logic [CHAR_W-1:0] ch);
        int k;
        for (k = 0; k < 58; k++) begin
            if (B58_ALPHABET[k] == ch) return k;
        end
        return -1;
    endfunction

    function automatic logic [CHAR_W-1:0] bad_char();
        logic [CHAR_W-1:0] c;
        do begin
            c = CHAR_W'($urandom_range(0, 255));
        end while (alpha_index(c) >= 0);
        return c;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int link_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_link) return 0;
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_number();
        int i;
        for (i = 0; i < BUF_BYTES; i++) num_bytes[i] = '0;
        ones_cnt   = 0;
        past_ones  = 1'b0;
        str_status = STS_OK;
    endtask

    // Multiply-by-58 accumulate; on the last character queue the decoded bytes
    task automatic base58_accumulate(input logic [CHAR_W-1:0] ch, input logic last);
        int       dig;
        int       carry;
        int       first;
        int       total;
        int       i;
        t_decoded res;
        if (str_status == STS_OK) begin
            taken_cnt++;
            dig = alpha_index(ch);
            if (dig < 0) begin
                str_status = STS_BADCHAR;
            end else if (dig == 0 && !past_ones) begin
                if (ones_cnt >= BUF_BYTES) str_status = STS_OVERFLOW;
                else ones_cnt++;
            end else begin
                past_ones = 1'b1;
                carry = dig;
                for (i = BUF_BYTES - 1; i >= 0; i--) begin
                    carry += RADIX * num_bytes[i];
                    num_bytes[i] = carry[BYTE_W-1:0];
                    carry = carry >> BYTE_W;
                end
                if (carry != 0) str_status = STS_OVERFLOW;
            end
        end
        if (last) begin
            strings_cnt++;
            if (str_status == STS_OK) begin
                first = 0;
                while (first < BUF_BYTES && num_bytes[first] == 0) first++;
                total = ones_cnt + BUF_BYTES - first;
                if (total > BUF_BYTES) begin
                    str_status = STS_OVERFLOW;
                end else if (total == 0) begin
                    decoded_q.push_back('{data: '0, last: 1'b1, st: STS_OK});
                end else begin
                    // zero byte per leading '1', then the significant bytes
                    for (i = 0; i < total; i++) begin
                        res.data = (i < ones_cnt) ? '0 : num_bytes[first + i - ones_cnt];
                        res.last = (i == total - 1);
                        res.st   = STS_OK;
                        decoded_q.push_back(res);
                    end
                end
            end
            if (str_status != STS_OK) begin
                error_strings++;
                decoded_q.push_back('{data: '0, last: 1'b1, st: str_status});
            end
            clear_number();
        end
    endtask

    // One character transfer, after a random gap
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int gap;
        gap = link_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_char <= ch;
        in_if.in_last <= last;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        sent_cnt++;
        base58_accumulate(ch, last);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_chars();
        int i;
        for (i = 0; i < chars_q.size(); i++) send_char(chars_q[i], i == chars_q.size() - 1);
        chars_q.delete();
    endtask

    // Append n alphabet characters with digits in [lo, hi]
    task automatic add_digits(input int n, input int lo, input int hi);
        repeat (n) chars_q.push_back(B58_ALPHABET[$urandom_range(lo, hi)]);
    endtask

    // Hold the input until every queued result has been seen
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Single characters: lone '1', top digit, invalid extremes
    task automatic test_single_chars();
        send_text("1");
        send_text("z");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Leading '1' gives zero bytes; a later '1' is digit zero
    task automatic test_leading_ones();
        send_text("112");
        send_text("21");
        send_text("1z1");
        wait_drained();
    endtask

    // First error wins and later characters are ignored
    task automatic test_error_hold();
        send_text("AOz");
        send_char(8'h80, 1'b0);
        send_text("2");
        send_text("2l");
        send_text("0I");
        wait_drained();
    endtask

    // Ones count past the buffer, total length past the buffer, full buffer,
    // carry out of the top byte
    task automatic test_buffer_limits();
        add_digits(BUF_BYTES + 1, 0, 0);
        send_chars();
        add_digits(1, 0, 0);
        add_digits(1, 57, 57);
        add_digits(42, 0, 57);
        send_chars();
        add_digits(1, 57, 57);
        add_digits(42, 0, 57);
        send_chars();
        add_digits(1, 57, 57);
        add_digits(43, 0, 57);
        send_chars();
        wait_drained();
    endtask

    // Mostly well-formed strings with random content, some broken ones and noise
    task automatic test_random_strings();
        int kind;
        int n;
        int start;
        start = sent_cnt;
        while (sent_cnt - start < RANDOM_CHARS) begin
            if ($urandom_range(0, 4) == 0) quiet_link = ~quiet_link;
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                add_digits($urandom_range(0, 3), 0, 0);
                add_digits($urandom_range(1, 10), 0, 57);
            end else if (kind < 62) begin
                add_digits(1, 1, 57);
                add_digits($urandom_range(20, 43), 0, 57);
            end else if (kind < 72) begin
                add_digits($urandom_range(28, 34), 0, 0);
                add_digits($urandom_range(0, 3), 0, 57);
            end else if (kind < 88) begin
                add_digits($urandom_range(1, 8), 0, 57);
                chars_q.insert($urandom_range(0, chars_q.size()), bad_char());
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) chars_q.push_back(CHAR_W'($urandom_range(0, 255)));
            end
            send_chars();
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        quiet_link = 1'b0;
        wait_drained();
    endtask

    // Result side: random stalls, compare each transfer with the oldest entry
    initial begin : result_check
        int       stall;
        t_decoded want;
        stall = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h out_last %0b status %0d",
                           out_if.out_byte, out_if.out_last, out_if.status);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    checked_cnt++;
                    if (out_if.out_byte !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_if.out_byte);
                        fail_cnt++;
                    end
                    if (out_if.out_last !== want.last) begin
                        $error("out_last: expected %0b, got %0b", want.last, out_if.out_last);
                        fail_cnt++;
                    end
                    if (out_if.status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, out_if.status);
                        fail_cnt++;
                    end
                end
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                stall = link_gap();
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_char <= '0;
        in_if.in_last <= 1'b0;
        clear_number();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_chars();
        test_leading_ones();
        test_error_hold();
        test_buffer_limits();
        test_random_strings();

        $display("Decoded %0d strings from %0d characters sent (%0d taken); %0d results checked.",
                 strings_cnt, sent_cnt, taken_cnt, checked_cnt);
        $display("%0d strings ended in an invalid character or buffer overflow.",
                 error_strings);
        if (fail_cnt == 0) begin
            $display("base58_decoder_top_tb: PASS");
        end else begin
            $display("base58_decoder_top_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("base58_decoder_top_tb: FAIL");
        $finish;
    end

endmodule
